/* hw/rtl/kws_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kws_pkg
// Shared constants, types and helpers of the kernel window smoother.
// ----------------------------------------------------------------------------
package kws_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int CTX_RESET    = 50;
    localparam int LEVEL_ONE    = 65536;
    // 0.75 in Q0.16
    localparam int KERNEL_PEAK  = 49152;

    // divider: numerator, divisor and quotient widths
    localparam int DIV_NUM_W    = 56;
    localparam int DIV_DEN_W    = 39;
    localparam int DIV_Q_W      = 17;

    typedef struct packed {
        logic [7:0]  chrom;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
        logic [15:0] reads;
        logic [16:0] frac;
    } entry_t;

    typedef struct packed {
        logic [7:0]  chrom;
        logic [31:0] center_pos;
        logic [39:0] coverage;
        logic [16:0] level;
        logic        truncated;
    } result_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    // slot arithmetic modulo the window depth; both operands stay below it
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= (SLOT_W + 1)'(WINDOW_DEPTH))
            begin
                s = s - (SLOT_W + 1)'(WINDOW_DEPTH);
            end
            return s[SLOT_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/kws_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kws_if
// Valid/ready channels of the kernel window smoother.
// ----------------------------------------------------------------------------
interface kws_site_if;
    logic        valid;
    logic        ready;
    logic [7:0]  site_chrom;
    logic [31:0] site_start;
    logic [31:0] site_end;
    logic [15:0] read_count;
    logic [16:0] meth_fraction;
    logic        end_of_stream;

    modport source (output valid, site_chrom, site_start, site_end, read_count,
                    meth_fraction, end_of_stream, input ready);
    modport sink   (input valid, site_chrom, site_start, site_end, read_count,
                    meth_fraction, end_of_stream, output ready);
endinterface

interface kws_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_chrom;
    logic [31:0] center_pos;
    logic [39:0] coverage;
    logic [16:0] smoothed_level;
    logic        truncated;
    logic        last_result;

    modport source (output valid, out_chrom, center_pos, coverage, smoothed_level,
                    truncated, last_result, input ready);
    modport sink   (input valid, out_chrom, center_pos, coverage, smoothed_level,
                    truncated, last_result, output ready);
endinterface

interface kws_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/kws_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kws_div
// Restoring divider, one quotient bit per cycle. The numerator must be
// below the divisor shifted up by the quotient width.
// ----------------------------------------------------------------------------
module kws_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kws_pkg::div_req_t req,
    output kws_pkg::div_rsp_t      rsp
);
    import kws_pkg::*;

    localparam int STEP_W = $clog2(DIV_Q_W);

    logic [DIV_NUM_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 fits;

    assign fits = (rem_reg >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_Q_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            den_reg <= DIV_NUM_W'({req.den, {(DIV_Q_W - 1){1'b0}}});
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
            den_reg <= den_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule
`default_nettype wire

/* hw/rtl/kernel_window_smoother.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kernel_window_smoother
// Epanechnikov kernel smoothing of methylation levels over a window of sites.
// ----------------------------------------------------------------------------
// Channels: site (sink) takes one site or an end-of-stream marker per item,
// result (source) gives the emitted centers in order, the last one of each
// input item marked by last_result. cfg writes the window half width (0 acts
// as 1) and is always ready; write it only while the block is idle.
// One input item at a time: site.ready is high only while idle. Each emitted
// center walks every stored site; each site on the center's chromosome
// within the context goes through one shared divider (divide start, weight
// divide and two multiply steps); a final ratio divide and hand-off follow.
// The divider sets the rate.
// Results leave through a one-item output register and one held result; a
// stalled receiver stops the block only when both are full. After reset the
// store is empty, the half width is 50 and no result is pending.
// ----------------------------------------------------------------------------
module kernel_window_smoother (
    input  wire logic    clk,
    input  wire logic    rst_n,
    kws_site_if.sink     site,
    kws_result_if.source result,
    kws_cfg_if.sink      cfg
);
    import kws_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_SCAN_CHK, S_EM_C, S_EM_C2, S_EM_RD, S_EM_D, S_EM_W,
        S_EM_DIV, S_EM_ACC, S_EM_ACC2, S_LVL, S_LVL_DIV, S_EM_OUT, S_EVICT,
        S_EVICT_CHK, S_FULL, S_STORE, S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] ctx_reg;
    logic [15:0] ctx_eff_reg, ctx_eff_next;
    logic [31:0] ctx2_reg, ctx2_next;
    logic [15:0] cfg_ctx_eff;

    entry_t      in_reg, in_next;
    logic        flush_reg, flush_next;

    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  done_reg, done_next;
    logic [SLOT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic              trunc_reg, trunc_next;

    logic [7:0]  c_chrom_reg, c_chrom_next;
    logic [31:0] c_start_reg, c_start_next;
    logic [7:0]  rc_reg, rc_next;
    logic [31:0] lhs_reg, lhs_next;

    logic [31:0] d2_reg, d2_next;
    logic [15:0] e_reads_reg, e_reads_next;
    logic [16:0] e_frac_reg, e_frac_next;
    logic [31:0] wr_reg, wr_next;
    logic [48:0] prod_reg, prod_next;
    logic [37:0] tot_reg, tot_next;
    logic [54:0] meth_reg, meth_next;
    logic [16:0] level_reg, level_next;

    result_t held_reg, held_next;
    logic    held_valid_reg, held_valid_next;
    result_t out_reg, out_next;
    logic    out_last_reg, out_last_next;
    logic    out_valid_reg, out_valid_next;

    entry_t            mem [WINDOW_DEPTH];
    entry_t            rd_q;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic              out_free;
    logic [31:0]       pos_gap;
    logic              passes;
    logic [31:0]       diff2;
    logic [47:0]       wnum;
    result_t           new_res;

    kws_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    assign cfg.ready   = 1'b1;
    assign site.ready  = (state_reg == S_IDLE);
    assign cfg_ctx_eff = (ctx_reg == '0) ? 16'd1 : ctx_reg;
    assign out_free    = !out_valid_reg || result.ready;

    assign pos_gap = (rd_q.start_pos > c_start_reg) ? (rd_q.start_pos - c_start_reg)
                                                    : (c_start_reg - rd_q.start_pos);
    assign passes = (rd_q.chrom == in_reg.chrom) &&
                    ({1'b0, in_reg.start_pos} <=
                     ({1'b0, rd_q.start_pos} + {17'd0, ctx_eff_reg}));
    assign diff2  = ctx2_reg - d2_reg;
    // 0.75 in Q0.16 is 3 * 2^14
    assign wnum   = {1'b0, diff2, 15'd0} + {2'b0, diff2, 14'd0};

    assign new_res.chrom      = c_chrom_reg;
    assign new_res.center_pos = c_start_reg;
    assign new_res.coverage   = {10'd0, tot_reg[37:8]};
    assign new_res.level      = level_reg;
    assign new_res.truncated  = trunc_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_reg;
        end
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= 16'(CTX_RESET);
        end
        else if (cfg.valid)
        begin
            ctx_reg <= cfg.data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ctx_eff_next    = ctx_eff_reg;
        ctx2_next       = ctx2_reg;
        in_next         = in_reg;
        flush_next      = flush_reg;
        oldest_next     = oldest_reg;
        fill_next       = fill_reg;
        done_next       = done_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        trunc_next      = trunc_reg;
        c_chrom_next    = c_chrom_reg;
        c_start_next    = c_start_reg;
        rc_next         = rc_reg;
        lhs_next        = lhs_reg;
        d2_next         = d2_reg;
        e_reads_next    = e_reads_reg;
        e_frac_next     = e_frac_reg;
        wr_next         = wr_reg;
        prod_next       = prod_reg;
        tot_next        = tot_reg;
        meth_next       = meth_reg;
        level_next      = level_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg;
        rd_addr         = oldest_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_add(oldest_reg, fill_reg[SLOT_W-1:0]);
        div_req.start   = 1'b0;
        div_req.num     = DIV_NUM_W'(wnum);
        div_req.den     = DIV_DEN_W'(ctx2_reg);

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (site.valid)
                begin
                    ctx_eff_next      = cfg_ctx_eff;
                    ctx2_next         = cfg_ctx_eff * cfg_ctx_eff;
                    in_next.chrom     = site.site_chrom;
                    in_next.start_pos = site.site_start;
                    in_next.end_pos   = site.site_end;
                    in_next.reads     = (site.read_count == '0) ? 16'd1 : site.read_count;
                    in_next.frac      = (site.meth_fraction > 17'(LEVEL_ONE)) ?
                                        17'(LEVEL_ONE) : site.meth_fraction;
                    flush_next        = site.end_of_stream;
                    state_next        = S_SCAN;
                end
            end

            S_SCAN:
            begin
                rd_addr = slot_add(oldest_reg, done_reg[SLOT_W-1:0]);
                if (done_reg < fill_reg)
                begin
                    state_next = S_SCAN_CHK;
                end
                else if (flush_reg)
                begin
                    oldest_next = '0;
                    fill_next   = '0;
                    done_next   = '0;
                    state_next  = S_FIN;
                end
                else
                begin
                    rc_next    = in_reg.chrom;
                    lhs_next   = (in_reg.start_pos >= {16'd0, ctx_eff_reg}) ?
                                 in_reg.start_pos - {16'd0, ctx_eff_reg} : '0;
                    state_next = S_EVICT;
                end
            end

            S_SCAN_CHK:
            begin
                if (!flush_reg && passes)
                begin
                    rc_next    = rd_q.chrom;
                    lhs_next   = (rd_q.start_pos >= {16'd0, ctx_eff_reg}) ?
                                 rd_q.start_pos - {16'd0, ctx_eff_reg} : '0;
                    state_next = S_EVICT;
                end
                else
                begin
                    k_next     = done_reg[SLOT_W-1:0];
                    trunc_next = 1'b0;
                    state_next = S_EM_C;
                end
            end

            S_EM_C:
            begin
                rd_addr    = slot_add(oldest_reg, k_reg);
                state_next = S_EM_C2;
            end

            S_EM_C2:
            begin
                c_chrom_next = rd_q.chrom;
                c_start_next = rd_q.start_pos;
                i_next       = '0;
                tot_next     = '0;
                meth_next    = '0;
                state_next   = S_EM_RD;
            end

            S_EM_RD:
            begin
                rd_addr = slot_add(oldest_reg, i_reg[SLOT_W-1:0]);
                if (i_reg < fill_reg)
                begin
                    state_next = S_EM_D;
                end
                else
                begin
                    state_next = S_LVL;
                end
            end

            S_EM_D:
            begin
                if ((rd_q.chrom == c_chrom_reg) && (pos_gap < {16'd0, ctx_eff_reg}))
                begin
                    d2_next      = pos_gap[15:0] * pos_gap[15:0];
                    e_reads_next = rd_q.reads;
                    e_frac_next  = rd_q.frac;
                    state_next   = S_EM_W;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_EM_RD;
                end
            end

            S_EM_W:
            begin
                div_req.start = 1'b1;
                state_next    = S_EM_DIV;
            end

            S_EM_DIV:
            begin
                if (div_rsp.done)
                begin
                    wr_next    = div_rsp.quot[15:0] * e_reads_reg;
                    state_next = S_EM_ACC;
                end
            end

            S_EM_ACC:
            begin
                prod_next  = wr_reg * e_frac_reg;
                tot_next   = tot_reg + {6'd0, wr_reg};
                state_next = S_EM_ACC2;
            end

            S_EM_ACC2:
            begin
                meth_next  = meth_reg + {6'd0, prod_reg};
                i_next     = i_reg + 1'b1;
                state_next = S_EM_RD;
            end

            S_LVL:
            begin
                if (tot_reg == '0)
                begin
                    level_next = '0;
                    state_next = S_EM_OUT;
                end
                else
                begin
                    // round to nearest, ties up
                    div_req.start = 1'b1;
                    div_req.num   = {1'b0, meth_reg} + {19'd0, tot_reg[37:1]};
                    div_req.den   = {1'b0, tot_reg};
                    state_next    = S_LVL_DIV;
                end
            end

            S_LVL_DIV:
            begin
                if (div_rsp.done)
                begin
                    level_next = (div_rsp.quot > 17'(LEVEL_ONE)) ? 17'(LEVEL_ONE)
                                                                 : div_rsp.quot;
                    state_next = S_EM_OUT;
                end
            end

            S_EM_OUT:
            begin
                // hold the newest result back until we know whether it is the last
                if (!held_valid_reg || out_free)
                begin
                    if (held_valid_reg)
                    begin
                        out_next       = held_reg;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                    end
                    held_next       = new_res;
                    held_valid_next = 1'b1;
                    if (trunc_reg)
                    begin
                        oldest_next = slot_add(oldest_reg, SLOT_W'(1));
                        fill_next   = fill_reg - 1'b1;
                        state_next  = S_STORE;
                    end
                    else
                    begin
                        done_next  = done_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_EVICT:
            begin
                rd_addr = oldest_reg;
                if (done_reg != '0)
                begin
                    state_next = S_EVICT_CHK;
                end
                else
                begin
                    state_next = S_FULL;
                end
            end

            S_EVICT_CHK:
            begin
                if ((rd_q.chrom == rc_reg) && (rd_q.end_pos > lhs_reg))
                begin
                    state_next = S_FULL;
                end
                else
                begin
                    oldest_next = slot_add(oldest_reg, SLOT_W'(1));
                    fill_next   = fill_reg - 1'b1;
                    done_next   = done_reg - 1'b1;
                    state_next  = S_EVICT;
                end
            end

            S_FULL:
            begin
                if (fill_reg == CNT_W'(WINDOW_DEPTH))
                begin
                    if (done_reg == '0)
                    begin
                        k_next     = '0;
                        trunc_next = 1'b1;
                        state_next = S_EM_C;
                    end
                    else
                    begin
                        done_next   = done_reg - 1'b1;
                        oldest_next = slot_add(oldest_reg, SLOT_W'(1));
                        fill_next   = fill_reg - 1'b1;
                        state_next  = S_STORE;
                    end
                end
                else
                begin
                    state_next = S_STORE;
                end
            end

            S_STORE:
            begin
                wr_en      = 1'b1;
                fill_next  = fill_reg + 1'b1;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (!held_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = held_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            oldest_reg     <= '0;
            fill_reg       <= '0;
            done_reg       <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            fill_reg       <= fill_next;
            done_reg       <= done_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_eff_reg  <= ctx_eff_next;
        ctx2_reg     <= ctx2_next;
        in_reg       <= in_next;
        flush_reg    <= flush_next;
        k_reg        <= k_next;
        i_reg        <= i_next;
        trunc_reg    <= trunc_next;
        c_chrom_reg  <= c_chrom_next;
        c_start_reg  <= c_start_next;
        rc_reg       <= rc_next;
        lhs_reg      <= lhs_next;
        d2_reg       <= d2_next;
        e_reads_reg  <= e_reads_next;
        e_frac_reg   <= e_frac_next;
        wr_reg       <= wr_next;
        prod_reg     <= prod_next;
        tot_reg      <= tot_next;
        meth_reg     <= meth_next;
        level_reg    <= level_next;
        held_reg     <= held_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.out_chrom      = out_reg.chrom;
    assign result.center_pos     = out_reg.center_pos;
    assign result.coverage       = out_reg.coverage;
    assign result.smoothed_level = out_reg.level;
    assign result.truncated      = out_reg.truncated;
    assign result.last_result    = out_last_reg;

endmodule
`default_nettype wire
